FILE: hdl/flptw_pkg.sv
// Shared constants, types and helpers for the four-level page-table walker.
`default_nettype none

package flptw_pkg;

  // Store geometry
  localparam int TABLE_FRAMES = 64;
  localparam int ENTRIES      = 512;
  localparam int IDX_W        = 9;
  localparam int FRAME_W      = $clog2(TABLE_FRAMES);
  localparam int ADDR_W       = FRAME_W + IDX_W;
  localparam int DEPTH        = TABLE_FRAMES * ENTRIES;
  localparam int PFN_W        = 40;
  localparam int VPN_W        = 36;
  localparam int PTE_W        = 64;

  // Entry bit positions
  localparam int BIT_PRESENT = 0;
  localparam int BIT_HUGE    = 7;
  localparam int PFN_LSB     = 12;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_UNMAP = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  // Result of checking one upper-level entry
  typedef struct packed {
    logic               absent;
    logic               range_err;
    logic [FRAME_W-1:0] next_frame;
  } step_res_t;

  // True when a physical frame number lies inside the store
  function automatic logic frame_in_range(input logic [PFN_W-1:0] pfn);
    return pfn < PFN_W'(TABLE_FRAMES);
  endfunction

  // Pick the 9-bit table index of a level out of the virtual page number
  function automatic logic [IDX_W-1:0] idx_of(input logic [VPN_W-1:0] vpn,
                                              input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      2'd3:    idx = vpn[35:27];
      2'd2:    idx = vpn[26:18];
      2'd1:    idx = vpn[17:9];
      default: idx = vpn[8:0];
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/flptw_store.sv
// Single-port table store with registered read data.
`default_nettype none

module flptw_store (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic                                we_i,
  input  wire logic [flptw_pkg::ADDR_W-1:0]        addr_i,
  input  wire logic [flptw_pkg::PTE_W-1:0]         wdata_i,
  output      logic [flptw_pkg::PTE_W-1:0]         rdata_o
);

  logic [flptw_pkg::PTE_W-1:0] mem [flptw_pkg::DEPTH];
  logic [flptw_pkg::PTE_W-1:0] rdata_q;

  // Write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/flptw_step.sv
// Level check unit: decides whether a walk stops at an upper-level entry.
`default_nettype none

module flptw_step (
  input  wire logic [flptw_pkg::PTE_W-1:0] entry_i,
  output      flptw_pkg::step_res_t        res_o
);

  logic [flptw_pkg::PFN_W-1:0] pfn;

  // Flag absent or huge entries, range-check the next table
  always_comb begin
    pfn              = entry_i[flptw_pkg::PFN_LSB +: flptw_pkg::PFN_W];
    res_o.absent     = !entry_i[flptw_pkg::BIT_PRESENT] || entry_i[flptw_pkg::BIT_HUGE];
    res_o.range_err  = !flptw_pkg::frame_in_range(pfn);
    res_o.next_frame = pfn[flptw_pkg::FRAME_W-1:0];
  end

endmodule

`default_nettype wire

FILE: hdl/four_level_page_table_walker.sv
// Top level: request sequencer around the table store and the level check unit.
//
//  channel   | handshake           | fields
//  ----------+---------------------+-----------------------------------------------
//  request   | start / busy        | req_type, root, virt, entry_frame/index/value
//  result    | done_o (1 cycle)    | pte_o, status_o
//
// A query walks the levels with one store read per level, the first issued from its own
// state and each later one in the cycle that checks the entry above; a walk may stop at
// an upper level. An unmap that reaches its leaf then writes zero to the leaf, a write
// stores its entry, and a request rejected at once (bad frame, unused code) is answered
// without leaving idle. The result word is shown in the cycle busy drops. After reset
// the store is cleared one entry per cycle with busy held high. The result cannot be
// stalled.
`default_nettype none

module four_level_page_table_walker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [51:0] root_i,
  input  wire logic [47:0] virt_i,
  input  wire logic [5:0]  entry_frame_i,
  input  wire logic [8:0]  entry_index_i,
  input  wire logic [63:0] entry_value_i,
  output      logic        done_o,
  output      logic [63:0] pte_o,
  output      logic [1:0]  status_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_ZERO  = 3'd5;

  localparam logic [flptw_pkg::ADDR_W-1:0] LAST_ADDR = flptw_pkg::ADDR_W'(flptw_pkg::DEPTH - 1);

  logic [2:0]                        state_q, state_d;
  logic [flptw_pkg::ADDR_W-1:0]      clr_q, clr_d;
  logic [1:0]                        lvl_q, lvl_d;
  logic [1:0]                        req_q, req_d;
  logic [flptw_pkg::VPN_W-1:0]       vpn_q, vpn_d;
  logic [flptw_pkg::FRAME_W-1:0]     frame_q, frame_d;
  logic [flptw_pkg::ADDR_W-1:0]      addr_q, addr_d;
  logic [flptw_pkg::PTE_W-1:0]       val_q, val_d;
  logic                              done_q, done_d;
  logic [flptw_pkg::PTE_W-1:0]       pte_q, pte_d;
  logic [1:0]                        status_q, status_d;

  logic                              mem_en, mem_we;
  logic [flptw_pkg::ADDR_W-1:0]      mem_addr;
  logic [flptw_pkg::PTE_W-1:0]       mem_wdata, mem_rdata;
  flptw_pkg::step_res_t              step;

  logic [flptw_pkg::PFN_W-1:0]       root_pfn, wr_pfn;
  logic                              descend;

  flptw_store u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  flptw_step u_step (
    .entry_i (mem_rdata),
    .res_o   (step)
  );

  assign root_pfn = root_i[flptw_pkg::PFN_LSB +: flptw_pkg::PFN_W];
  assign wr_pfn   = {{(flptw_pkg::PFN_W - 6){1'b0}}, entry_frame_i};
  assign descend  = (lvl_q != 2'd0) && !step.absent && !step.range_err;

  // Drive the store port: clearing sweep, entry writes, level reads
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = val_q;
      end
      S_ZERO: begin
        mem_we = 1'b1;
      end
      S_READ: begin
        mem_en   = 1'b1;
        mem_addr = {frame_q, flptw_pkg::idx_of(vpn_q, lvl_q)};
      end
      S_CHECK: begin
        mem_en   = descend;
        mem_addr = {step.next_frame, flptw_pkg::idx_of(vpn_q, lvl_q - 2'd1)};
      end
      default: ;
    endcase
  end

  // Sequence requests through the levels
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    lvl_d    = lvl_q;
    req_d    = req_q;
    vpn_d    = vpn_q;
    frame_d  = frame_q;
    addr_d   = addr_q;
    val_d    = val_q;
    done_d   = 1'b0;
    pte_d    = pte_q;
    status_d = status_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_d   = req_type_i;
          vpn_d   = virt_i[47:12];
          frame_d = root_pfn[flptw_pkg::FRAME_W-1:0];
          addr_d  = {wr_pfn[flptw_pkg::FRAME_W-1:0], entry_index_i};
          val_d   = entry_value_i;
          lvl_d   = 2'd3;
          pte_d   = '0;
          priority if (req_type_i == flptw_pkg::REQ_WRITE) begin
            if (flptw_pkg::frame_in_range(wr_pfn)) begin
              state_d = S_WRITE;
            end else begin
              done_d   = 1'b1;
              status_d = flptw_pkg::ST_RANGE;
            end
          end else if (req_type_i == flptw_pkg::REQ_QUERY ||
                       req_type_i == flptw_pkg::REQ_UNMAP) begin
            if (flptw_pkg::frame_in_range(root_pfn)) begin
              state_d = S_READ;
            end else begin
              done_d   = 1'b1;
              status_d = flptw_pkg::ST_RANGE;
            end
          end else begin
            done_d   = 1'b1;
            status_d = flptw_pkg::ST_OK;
          end
        end
      end
      S_WRITE, S_ZERO: begin
        done_d   = 1'b1;
        status_d = flptw_pkg::ST_OK;
        state_d  = S_IDLE;
      end
      S_READ: begin
        addr_d  = mem_addr;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        priority if (lvl_q == 2'd0) begin
          if (req_q == flptw_pkg::REQ_QUERY) begin
            done_d   = 1'b1;
            status_d = flptw_pkg::ST_OK;
            pte_d    = mem_rdata;
            state_d  = S_IDLE;
          end else begin
            state_d = S_ZERO;
          end
        end else if (step.absent) begin
          done_d   = 1'b1;
          status_d = flptw_pkg::ST_ABSENT;
          state_d  = S_IDLE;
        end else if (step.range_err) begin
          done_d   = 1'b1;
          status_d = flptw_pkg::ST_RANGE;
          state_d  = S_IDLE;
        end else begin
          lvl_d  = lvl_q - 2'd1;
          addr_d = mem_addr;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      lvl_q   <= '0;
      req_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      lvl_q   <= lvl_d;
      req_q   <= req_d;
      done_q  <= done_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    vpn_q    <= vpn_d;
    frame_q  <= frame_d;
    addr_q   <= addr_d;
    val_q    <= val_d;
    pte_q    <= pte_d;
    status_q <= status_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign pte_o    = pte_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

FILE: hdl/flptw_chk.sv
// Port-level checker for the page-table walker, bound to the top level.
`default_nettype none

module flptw_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [63:0] pte_o,
  input wire logic [1:0]  status_o
);

  // An accepted word is either answered at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted request neither answered nor in progress");

  // A result word appears only once the block is free again
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Status is one of the three defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == flptw_pkg::ST_OK || status_o == flptw_pkg::ST_ABSENT ||
                status_o == flptw_pkg::ST_RANGE))
    else $error("undefined status code");

  // A failed walk never returns an entry
  a_fail_zero_pte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != flptw_pkg::ST_OK) |-> (pte_o == 64'd0))
    else $error("non-zero entry on failed request");

endmodule

bind four_level_page_table_walker flptw_chk u_flptw_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .pte_o    (pte_o),
  .status_o (status_o)
);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the four-level page-table walker: directed and random words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code with no defined action
  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam int RANDOM_REQUESTS = 500;
  localparam int QUIET_TAIL      = 60;
  localparam int SETTLE_CYCLES   = 20;
  // Clearing pass after reset writes every store entry with busy held; the limit allows for it
  localparam int STALL_LIMIT     = 4 * flptw_pkg::DEPTH;

  typedef struct {
    logic [1:0]  kind;
    logic [51:0] root;
    logic [47:0] virt;
    logic [5:0]  frame;
    logic [8:0]  index;
    logic [63:0] value;
    bit          drain;
  } walk_req_t;

  typedef struct {
    logic [63:0] pte;
    logic [1:0]  status;
  } walk_result_t;

  typedef struct {
    logic [5:0]  root_frame;
    logic [47:0] va;
  } mapping_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic [1:0]  req_type_i    = '0;
  logic [51:0] root_i        = '0;
  logic [47:0] virt_i        = '0;
  logic [5:0]  entry_frame_i = '0;
  logic [8:0]  entry_index_i = '0;
  logic [63:0] entry_value_i = '0;
  logic        busy;
  logic        done_o;
  logic [63:0] pte_o;
  logic [1:0]  status_o;

  walk_req_t    request_q[$];
  walk_result_t expected_results[$];
  mapping_t     recent_maps[$];
  bit [63:0]    shadow_tables [flptw_pkg::DEPTH];

  bit word_taken     = 1'b0;
  int total_requests = 0;
  int sent_count     = 0;
  int gap_left       = 0;
  int stall_cycles   = 0;
  int error_count    = 0;

  four_level_page_table_walker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .root_i        (root_i),
    .virt_i        (virt_i),
    .entry_frame_i (entry_frame_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .done_o        (done_o),
    .pte_o         (pte_o),
    .status_o      (status_o)
  );

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Frame number that lies beyond the store
  function automatic logic [39:0] far_pfn();
    logic [39:0] p;
    p = 40'(rand64());
    p[flptw_pkg::FRAME_W + $urandom_range(0, 39 - flptw_pkg::FRAME_W)] = 1'b1;
    return p;
  endfunction

  function automatic logic [51:0] root_of(input logic [5:0] frame);
    return {40'(frame), 12'($urandom)};
  endfunction

  // Present, non-huge pointer to a frame, other bits random
  function automatic logic [63:0] upper_entry(input logic [39:0] pfn);
    logic [63:0] e;
    e = rand64();
    e[51:flptw_pkg::PFN_LSB]   = pfn;
    e[flptw_pkg::BIT_PRESENT]  = 1'b1;
    e[flptw_pkg::BIT_HUGE]     = 1'b0;
    return e;
  endfunction

  // Break a pointer: absent, huge or out of range
  function automatic logic [63:0] spoil_entry(input logic [63:0] e);
    logic [63:0] r;
    r = e;
    case ($urandom_range(0, 2))
      0:       r[flptw_pkg::BIT_PRESENT] = 1'b0;
      1:       r[flptw_pkg::BIT_HUGE] = 1'b1;
      default: r[51:flptw_pkg::PFN_LSB] = far_pfn();
    endcase
    return r;
  endfunction

  // Walk the shadow tables to the leaf slot
  function automatic logic [1:0] walk_tables(input logic [51:0] root, input logic [47:0] va,
                                             output int slot);
    logic [39:0] pfn;
    logic [63:0] e;
    logic [8:0]  idx;
    pfn  = root[51:flptw_pkg::PFN_LSB];
    slot = 0;
    for (int lvl = 3; lvl >= 1; lvl--) begin
      idx = va[flptw_pkg::PFN_LSB + flptw_pkg::IDX_W * lvl +: flptw_pkg::IDX_W];
      if (pfn >= flptw_pkg::TABLE_FRAMES) return flptw_pkg::ST_RANGE;
      e = shadow_tables[int'(pfn[flptw_pkg::FRAME_W-1:0]) * flptw_pkg::ENTRIES + int'(idx)];
      if (!e[flptw_pkg::BIT_PRESENT] || e[flptw_pkg::BIT_HUGE]) return flptw_pkg::ST_ABSENT;
      pfn = e[51:flptw_pkg::PFN_LSB];
    end
    if (pfn >= flptw_pkg::TABLE_FRAMES) return flptw_pkg::ST_RANGE;
    slot = int'(pfn[flptw_pkg::FRAME_W-1:0]) * flptw_pkg::ENTRIES + int'(va[20:12]);
    return flptw_pkg::ST_OK;
  endfunction

  // Apply one request to the shadow tables and give the result word it should produce
  task automatic predict_request(input walk_req_t r, output walk_result_t res);
    int slot;
    res.pte    = '0;
    res.status = flptw_pkg::ST_OK;
    case (r.kind)
      flptw_pkg::REQ_WRITE: begin
        if (r.frame < flptw_pkg::TABLE_FRAMES) begin
          shadow_tables[int'(r.frame) * flptw_pkg::ENTRIES + int'(r.index)] = r.value;
        end else begin
          res.status = flptw_pkg::ST_RANGE;
        end
      end
      flptw_pkg::REQ_QUERY, flptw_pkg::REQ_UNMAP: begin
        res.status = walk_tables(r.root, r.virt, slot);
        if (res.status == flptw_pkg::ST_OK) begin
          if (r.kind == flptw_pkg::REQ_QUERY) res.pte = shadow_tables[slot];
          else shadow_tables[slot] = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_req(input logic [1:0] kind, input logic [51:0] root,
                          input logic [47:0] virt, input logic [5:0] frame,
                          input logic [8:0] index, input logic [63:0] value, input bit drain);
    walk_req_t r;
    r.kind  = kind;
    r.root  = root;
    r.virt  = virt;
    r.frame = frame;
    r.index = index;
    r.value = value;
    r.drain = drain;
    request_q.push_back(r);
  endtask

  task automatic push_write(input logic [5:0] frame, input logic [8:0] index,
                            input logic [63:0] value);
    push_req(flptw_pkg::REQ_WRITE, 52'(rand64()), 48'(rand64()), frame, index, value, 1'b0);
  endtask

  task automatic push_walk(input logic [1:0] kind, input logic [51:0] root,
                           input logic [47:0] va);
    push_req(kind, root, va, 6'($urandom), 9'($urandom), rand64(), 1'b0);
  endtask

  // Build a four-level chain for a random address, sometimes broken, then walk it
  task automatic map_and_probe();
    logic [5:0]  at [4];
    logic [8:0]  ix [4];
    logic [63:0] e [4];
    logic [5:0]  f_top;
    logic [47:0] va;
    logic [47:0] va_p;
    int          bad;
    int          probes;
    f_top = 6'($urandom_range(0, 7));
    va    = 48'(rand64());
    at[0] = f_top;
    at[1] = 6'($urandom);
    at[2] = 6'($urandom);
    at[3] = 6'($urandom);
    ix[0] = va[47:39];
    ix[1] = va[38:30];
    ix[2] = va[29:21];
    ix[3] = va[20:12];
    e[0]  = upper_entry(40'(at[1]));
    e[1]  = upper_entry(40'(at[2]));
    e[2]  = upper_entry(40'(at[3]));
    e[3]  = rand64();
    bad   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : -1;
    if (bad >= 0) e[bad] = spoil_entry(e[bad]);
    for (int k = 0; k < 4; k++) begin
      push_req(flptw_pkg::REQ_WRITE, 52'(rand64()), 48'(rand64()), at[k], ix[k], e[k],
               k == 0 && $urandom_range(0, 39) == 0);
    end
    probes = $urandom_range(1, 3);
    for (int k = 0; k < probes; k++) begin
      va_p = va;
      if ($urandom_range(0, 3) == 0) va_p[20:12] = 9'($urandom);
      push_walk(($urandom_range(0, 3) == 0) ? flptw_pkg::REQ_UNMAP : flptw_pkg::REQ_QUERY,
                root_of(f_top), va_p);
    end
    recent_maps.push_back('{f_top, va});
    if (recent_maps.size() > 16) void'(recent_maps.pop_front());
  endtask

  // Fill the request queue, then wait for the run to drain
  initial begin : stimulus
    logic [63:0] e;
    mapping_t    m;
    logic [47:0] va;
    int          pick;

    // Directed: cleared store, extremes, spare code, out-of-range roots
    push_walk(flptw_pkg::REQ_QUERY, root_of(6'd0), 48'h0);
    push_write(6'h3F, 9'h1FF, '1);
    push_write(6'h00, 9'h000, '0);
    push_req(REQ_SPARE, '1, '1, '1, '1, '1, 1'b0);
    push_walk(flptw_pkg::REQ_QUERY, '1, '1);
    push_walk(flptw_pkg::REQ_UNMAP, '1, '1);

    // Directed: full chain along index 511; leaf returned even when absent and huge
    push_write(6'd1, 9'h1FF, upper_entry(40'd2));
    push_write(6'd2, 9'h1FF, upper_entry(40'd3));
    push_write(6'd3, 9'h1FF, upper_entry(40'd4));
    push_write(6'd4, 9'h1FF, 64'hFFFF_FFFF_FFFF_FFFE);
    push_walk(flptw_pkg::REQ_QUERY, root_of(6'd1), '1);
    push_walk(flptw_pkg::REQ_UNMAP, root_of(6'd1), '1);
    push_walk(flptw_pkg::REQ_QUERY, root_of(6'd1), '1);

    // Directed: huge page in the middle level
    e = upper_entry(40'd3);
    e[flptw_pkg::BIT_HUGE] = 1'b1;
    push_write(6'd4, 9'h1FF, '1);
    push_write(6'd2, 9'h1FF, e);
    push_walk(flptw_pkg::REQ_QUERY, root_of(6'd1), '1);

    // Directed: leaf frame beyond the store, then a followed pointer beyond it
    push_write(6'd2, 9'h1FF, upper_entry(40'd3));
    push_write(6'd3, 9'h1FF, upper_entry(far_pfn()));
    push_walk(flptw_pkg::REQ_QUERY, root_of(6'd1), '1);
    push_write(6'd1, 9'h1FF, upper_entry(40'hF_FFFF_FFFF));
    push_walk(flptw_pkg::REQ_UNMAP, root_of(6'd1), '1);

    // Directed: frame 0 pointing at itself along index 0
    push_write(6'd0, 9'h000, upper_entry(40'd0));
    push_walk(flptw_pkg::REQ_QUERY, root_of(6'd0), 48'h0);
    push_walk(flptw_pkg::REQ_UNMAP, root_of(6'd0), 48'h0);
    push_walk(flptw_pkg::REQ_QUERY, root_of(6'd0), 48'h0);

    // Random: hold off until the directed part has fully drained
    push_req(flptw_pkg::REQ_QUERY, root_of(6'd1), '1, '0, '0, '0, 1'b1);
    pick = request_q.size();
    while (request_q.size() - pick < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 99) < 55) begin
        map_and_probe();
      end else if ($urandom_range(0, 2) != 0 && recent_maps.size() != 0) begin
        m  = recent_maps[$urandom_range(0, recent_maps.size() - 1)];
        va = m.va;
        if ($urandom_range(0, 2) == 0) va[29:12] = 18'($urandom);
        push_walk(($urandom_range(0, 4) == 0) ? flptw_pkg::REQ_UNMAP : flptw_pkg::REQ_QUERY,
                  root_of(m.root_frame), va);
      end else begin
        case ($urandom_range(0, 2))
          0:       push_req(2'($urandom), 52'(rand64()), 48'(rand64()), 6'($urandom),
                            9'($urandom), rand64(), 1'b0);
          1:       push_walk(2'($urandom_range(1, 2)), {far_pfn(), 12'($urandom)}, 48'(rand64()));
          default: push_walk(2'($urandom_range(1, 2)), root_of(6'($urandom)), 48'(rand64()));
        endcase
      end
    end
    total_requests = request_q.size();

    // Hold reset, then release it at a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (request_q.size() == 0 && start == 1'b0 && expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Drive request words at the falling edge, with random gaps and drain pauses
  always @(negedge clk_i) begin : driver
    walk_req_t nxt;
    bit        send;
    send = 1'b0;
    if (rst_ni && !(start && !word_taken)) begin
      if (gap_left == 0 && request_q.size() != 0 && sent_count + QUIET_TAIL < total_requests &&
          $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 18);
      end
      if (gap_left != 0) begin
        gap_left--;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].drain && expected_results.size() != 0)) begin
        send = 1'b1;
      end
      if (send) begin
        nxt = request_q.pop_front();
        req_type_i    <= nxt.kind;
        root_i        <= nxt.root;
        virt_i        <= nxt.virt;
        entry_frame_i <= nxt.frame;
        entry_index_i <= nxt.index;
        entry_value_i <= nxt.value;
        sent_count++;
      end
      start <= send;
    end
  end

  // Check result words and predict accepted requests at the rising edge
  always @(posedge clk_i) begin : monitor
    walk_req_t    r;
    walk_result_t want;
    bit           moved;
    if (rst_ni) begin
      moved = 1'b0;
      word_taken <= start && !busy;
      if (done_o) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result word with none expected: pte %h status %0d", pte_o, status_o);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (pte_o !== want.pte) begin
            $error("pte: expected %h, got %h", want.pte, pte_o);
            error_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        moved   = 1'b1;
        r.kind  = req_type_i;
        r.root  = root_i;
        r.virt  = virt_i;
        r.frame = entry_frame_i;
        r.index = entry_index_i;
        r.value = entry_value_i;
        r.drain = 1'b0;
        predict_request(r, want);
        expected_results.push_back(want);
      end
      // Watchdog: give up after a long stretch with no word moving
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end else begin
      word_taken <= 1'b0;
    end
  end

endmodule
